FILE: rtl/sqlk_pkg.sv
// ----------------------------------------------------------------------------
// sqlk_pkg
// Shared types and codes for the sequence-lock read section tracker: operation
// and status codes, the scan token that walks the slot chain, the slot write.
// ----------------------------------------------------------------------------
package sqlk_pkg;

   // operation carried in the request tuser
   typedef enum logic [1:0] {
      OP_BEGIN    = 2'd0,
      OP_END      = 2'd1,
      OP_IGN_ON   = 2'd2,
      OP_IGN_OFF  = 2'd3
   } op_type;

   // status reported with every result beat
   typedef enum logic [3:0] {
      ST_OK          = 4'd0,
      ST_SKIPPED     = 4'd1,
      ST_ZERO_ADDR   = 4'd2,
      ST_FULL        = 4'd3,
      ST_NOT_HELD    = 4'd4,
      ST_OVERFLOW    = 4'd5,
      ST_UNDERFLOW   = 4'd6,
      ST_ALREADY_IGN = 4'd7,
      ST_NOT_IGN     = 4'd8
   } status_type;

   localparam int ADDR_W = 64;

   // scan token handed from cell to cell (slot index travels beside it)
   typedef struct packed {
      logic              valid;
      logic              op_end;
      logic              found;
      logic [ADDR_W-1:0] addr;
   } token_type;

   // slot write broadcast from the controller (index travels beside it)
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } slot_wr_type;

endpackage

FILE: rtl/seqlock_read_section_tracker_top.sv
// ----------------------------------------------------------------------------
// seqlock_read_section_tracker_top
// Tracks open sequence-lock read sections in a chain of slot cells.
//
// Request beats carry the operation on req_tuser and the lock address on
// req_tdata; each request gives exactly one response beat on rsp_tdata with
// status, slot used, nesting depth and the skip flag.
// Begin and end beats that reach the slot table send a scan token down the
// chain of SLOTS cells, one cell per cycle; the commit follows when the token
// leaves the last cell, and the result then moves through the finish state
// to the output register. Ignore operations and rejected begin/end beats
// skip the chain and go straight to the finish state. One item is in flight
// at a time; the next request is taken once the previous result sits in the
// output register. Reset (synchronous) empties every slot, clears the skip
// flag and the depth, and drops any pending response. When the receiver
// stalls, the result holds in the output register and one further item may
// finish into the pending stage before req_tready stays low.
// ----------------------------------------------------------------------------
module seqlock_read_section_tracker_top #(
   parameter int SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // lock_address[63:0]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status[3:0], slot_used[6:4],
                                    // nesting_depth[10:7], ignoring[11], zero
);

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DEPTH_W = $clog2(SLOTS + 2);
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(SLOTS + 1);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type               state_ff, state_in;
   logic                    skip_ff, skip_in;
   logic [DEPTH_W-1:0]      depth_ff, depth_in;
   sqlk_pkg::status_type    pend_status_ff, pend_status_in;
   logic [SLOT_W-1:0]       pend_slot_ff, pend_slot_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [15:0]             rsp_data_ff, rsp_data_in;

   sqlk_pkg::token_type     tok [SLOTS+1];
   logic [SLOT_W-1:0]       tok_idx [SLOTS+1];
   sqlk_pkg::token_type     tok_first;
   sqlk_pkg::slot_wr_type   wr;
   logic [SLOT_W-1:0]       wr_idx;

   sqlk_pkg::op_type        op;
   logic                    req_accept;
   logic                    needs_scan;
   logic                    out_load;
   logic [DEPTH_W+3:0]      depth_ext;
   logic [SLOT_W+2:0]       slot_ext;
   sqlk_pkg::token_type     tok_last;
   logic [SLOT_W-1:0]       idx_last;

   // request decode
   assign op         = sqlk_pkg::op_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign needs_scan = ((op == sqlk_pkg::OP_BEGIN) || (op == sqlk_pkg::OP_END))
                       && !skip_ff && (req_tdata != '0);

   // token launched into the first cell
   always_comb begin
      tok_first        = '0;
      tok_first.valid  = req_accept && needs_scan;
      tok_first.op_end = (op == sqlk_pkg::OP_END);
      tok_first.addr   = req_tdata;
   end

   assign tok[0]     = tok_first;
   assign tok_idx[0] = '0;

   // chain of slot cells
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      sqlk_cell #(
         .SLOT_W   (SLOT_W),
         .CELL_IDX (g)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (tok[g]),
         .idx_in  (tok_idx[g]),
         .tok_out (tok[g+1]),
         .idx_out (tok_idx[g+1]),
         .wr      (wr),
         .wr_idx  (wr_idx)
      );
   end

   assign tok_last = tok[SLOTS];
   assign idx_last = tok_idx[SLOTS];

   // sequencing, checks and commit
   always_comb begin
      state_in       = state_ff;
      skip_in        = skip_ff;
      depth_in       = depth_ff;
      pend_status_in = pend_status_ff;
      pend_slot_in   = pend_slot_ff;
      wr             = '0;
      wr_idx         = '0;
      out_load       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               if (needs_scan) begin
                  state_in = S_SCAN;
               end else begin
                  state_in     = S_FINISH;
                  pend_slot_in = '0;
                  case (op)
                     sqlk_pkg::OP_BEGIN, sqlk_pkg::OP_END: begin
                        pend_status_in = skip_ff ? sqlk_pkg::ST_SKIPPED
                                                 : sqlk_pkg::ST_ZERO_ADDR;
                     end
                     sqlk_pkg::OP_IGN_ON: begin
                        if (skip_ff) begin
                           pend_status_in = sqlk_pkg::ST_ALREADY_IGN;
                        end else if (depth_ff >= DEPTH_MAX) begin
                           pend_status_in = sqlk_pkg::ST_OVERFLOW;
                        end else begin
                           pend_status_in = sqlk_pkg::ST_OK;
                           skip_in        = 1'b1;
                           depth_in       = depth_ff + 1'b1;
                        end
                     end
                     default: begin
                        if (!skip_ff) begin
                           pend_status_in = sqlk_pkg::ST_NOT_IGN;
                        end else if (depth_ff == '0) begin
                           pend_status_in = sqlk_pkg::ST_UNDERFLOW;
                        end else begin
                           pend_status_in = sqlk_pkg::ST_OK;
                           skip_in        = 1'b0;
                           depth_in       = depth_ff - 1'b1;
                        end
                     end
                  endcase
               end
            end
         end
         S_SCAN: begin
            if (tok_last.valid) begin
               state_in     = S_FINISH;
               pend_slot_in = '0;
               if (!tok_last.found) begin
                  pend_status_in = tok_last.op_end ? sqlk_pkg::ST_NOT_HELD
                                                   : sqlk_pkg::ST_FULL;
               end else if (!tok_last.op_end) begin
                  if (depth_ff >= DEPTH_MAX) begin
                     pend_status_in = sqlk_pkg::ST_OVERFLOW;
                  end else begin
                     pend_status_in = sqlk_pkg::ST_OK;
                     pend_slot_in   = idx_last;
                     wr.en          = 1'b1;
                     wr.addr        = tok_last.addr;
                     wr_idx         = idx_last;
                     depth_in       = depth_ff + 1'b1;
                  end
               end else begin
                  if (depth_ff == '0) begin
                     pend_status_in = sqlk_pkg::ST_UNDERFLOW;
                  end else begin
                     pend_status_in = sqlk_pkg::ST_OK;
                     pend_slot_in   = idx_last;
                     wr.en          = 1'b1;
                     wr.addr        = '0;
                     wr_idx         = idx_last;
                     depth_in       = depth_ff - 1'b1;
                  end
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response beat assembly
   assign depth_ext    = {4'b0, depth_ff};
   assign slot_ext     = {3'b0, pend_slot_ff};
   assign rsp_data_in  = out_load ? {4'b0, skip_ff, depth_ext[3:0], slot_ext[2:0],
                                     pend_status_ff}
                                  : rsp_data_ff;
   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp_tready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         skip_ff      <= 1'b0;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         skip_ff      <= skip_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_status_ff <= pend_status_in;
      pend_slot_ff   <= pend_slot_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // slot writes only come from a finished scan
   a_wr_in_scan: assert property (@(posedge clock) disable iff (reset)
      wr.en |-> (state_ff == S_SCAN) && tok_last.valid)
      else $error("slot write outside scan commit");

   // a token leaves the chain only while the controller waits for it
   a_tok_in_scan: assert property (@(posedge clock) disable iff (reset)
      tok_last.valid |-> (state_ff == S_SCAN))
      else $error("scan token arrived while not scanning");

   // depth never passes its ceiling
   a_depth_max: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_MAX)
      else $error("nesting depth beyond ceiling");

   // a failed item reports no slot
   a_slot_on_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[3:0] != sqlk_pkg::ST_OK)) |-> (rsp_data_ff[6:4] == 3'd0))
      else $error("slot reported on failed item");

   // a change of the skip flag always moves the depth
   a_skip_depth: assert property (@(posedge clock) disable iff (reset)
      (skip_ff != $past(skip_ff)) |-> (depth_ff != $past(depth_ff)))
      else $error("skip flag changed without depth change");

endmodule

FILE: rtl/sqlk_cell.sv
// ----------------------------------------------------------------------------
// sqlk_cell
// One slot of the tracker: holds a lock address (zero means empty), inspects
// the passing scan token and hands it on to the next cell through a register.
// ----------------------------------------------------------------------------
module sqlk_cell #(
   parameter int SLOT_W   = 3,
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sqlk_pkg::token_type           tok_in,
   input  logic [SLOT_W-1:0]             idx_in,
   output sqlk_pkg::token_type           tok_out,
   output logic [SLOT_W-1:0]             idx_out,
   input  sqlk_pkg::slot_wr_type         wr,
   input  logic [SLOT_W-1:0]             wr_idx
);

   localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

   logic [sqlk_pkg::ADDR_W-1:0] slot_addr_ff;
   sqlk_pkg::token_type         tok_ff, tok_in_upd;
   logic [SLOT_W-1:0]           idx_ff, idx_in_upd;
   logic                        hit;

   // end takes the last match along the chain, begin the first empty slot
   always_comb begin
      hit        = tok_in.op_end ? (slot_addr_ff == tok_in.addr)
                                 : (!tok_in.found && (slot_addr_ff == '0));
      tok_in_upd = tok_in;
      idx_in_upd = idx_in;
      if (hit) begin
         tok_in_upd.found = 1'b1;
         idx_in_upd       = MY_IDX;
      end
   end

   // token stage towards the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
         idx_ff <= '0;
      end else begin
         tok_ff <= tok_in_upd;
         idx_ff <= idx_in_upd;
      end
   end

   // slot contents, written by the controller commit
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_addr_ff <= '0;
      end else if (wr.en && (wr_idx == MY_IDX)) begin
         slot_addr_ff <= wr.addr;
      end
   end

   assign tok_out = tok_ff;
   assign idx_out = idx_ff;

endmodule
